FILE: hdl/mfba_pkg.sv
// Shared widths and default sizes for the min-fill block arena allocator.
`timescale 1ns / 1ps

package mfba_pkg;

   localparam int DEF_BLOCK_BYTES  = 65536;
   localparam int DEF_MAX_BLOCKS   = 256;
   localparam int DEF_HEADER_BYTES = 8;

   localparam int REQ_W      = 24;
   localparam int FILL_W     = 25;
   localparam int BIDX_W     = 8;
   localparam int OFF_W      = 17;
   localparam int RSP_DATA_W = 32;

endpackage

FILE: hdl/mfba_ram.sv
// Two-read, one-write memory with registered read data.
`timescale 1ns / 1ps

module mfba_ram #(
   parameter int WIDTH = mfba_pkg::FILL_W,
   parameter int DEPTH = mfba_pkg::DEF_MAX_BLOCKS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr0,
   input  logic [AW-1:0]    rd_addr1,
   output logic [WIDTH-1:0] rd_data0,
   output logic [WIDTH-1:0] rd_data1
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= mem_ff[rd_addr0];
         rd_data1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

FILE: hdl/min_fill_block_arena_allocator.sv
// A request that fits the current block goes from the check state to the done state, and the
// block takes the next request from the edge on which its result shows.
// Otherwise the root is sifted down in three steps per heap level (heap read, fill read,
// compare), and a new block is sifted up in up to three steps per level; one request is
// in work at a time.
// Synchronous reset makes block 0 current with the reserved prefix; memories need no clearing.
`timescale 1ns / 1ps

module min_fill_block_arena_allocator #(
   parameter int BLOCK_BYTES  = mfba_pkg::DEF_BLOCK_BYTES,
   parameter int MAX_BLOCKS   = mfba_pkg::DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = mfba_pkg::DEF_HEADER_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mfba_pkg::REQ_W-1:0]      req_tdata,  // request_bytes [23:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mfba_pkg::RSP_DATA_W-1:0] rsp_tdata,  // block_index [7:0], byte_offset [24:8]
   output logic                            rsp_tuser   // status
);
   import mfba_pkg::*;

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int CH_W   = IDX_W + 2;
   localparam int SUM_W  = FILL_W + 1;
   localparam int BLKX_W = IDX_W + BIDX_W;
   localparam logic [SUM_W-1:0]  BLOCK_LIM = SUM_W'(BLOCK_BYTES);
   localparam logic [FILL_W-1:0] PREFIX    = FILL_W'(MAX_BLOCKS * 8 + HEADER_BYTES);
   localparam logic [FILL_W-1:0] HDR       = FILL_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BLOCKS);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_CHECK   = 10'b0000000010,
      ST_DN_HEAP = 10'b0000000100,
      ST_DN_FILL = 10'b0000001000,
      ST_DN_CMP  = 10'b0000010000,
      ST_DN_DONE = 10'b0000100000,
      ST_UP_HEAP = 10'b0001000000,
      ST_UP_FILL = 10'b0010000000,
      ST_UP_CMP  = 10'b0100000000,
      ST_DONE    = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [REQ_W-1:0]    req_bytes_ff, req_bytes_in;
   logic [IDX_W-1:0]    cur_blk_ff, cur_blk_in;
   logic [FILL_W-1:0]   cur_fill_ff, cur_fill_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    mov_blk_ff, mov_blk_in;
   logic [FILL_W-1:0]   mov_key_ff, mov_key_in;
   logic [IDX_W-1:0]    root_ff, root_in;
   logic [FILL_W-1:0]   f_ff, f_in;
   logic                fits_ff, fits_in;
   logic                res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_blk_ff, res_blk_in;
   logic [FILL_W-1:0]   res_off_ff, res_off_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [BIDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [OFF_W-1:0]    rsp_offset_ff, rsp_offset_in;

   logic                heap_we, heap_re;
   logic [IDX_W-1:0]    heap_wa, heap_wd, heap_ra0, heap_ra1, heap_rd0, heap_rd1;
   logic                fill_we, fill_re;
   logic [IDX_W-1:0]    fill_wa, fill_ra0, fill_ra1;
   logic [FILL_W-1:0]   fill_wd, fill_rd0, fill_rd1;

   logic [CH_W-1:0]     left_pos, right_pos;
   logic                has_left, has_right, pick_right, descend, fits_new, full;
   logic [FILL_W-1:0]   child_key, f_new;
   logic [IDX_W-1:0]    child_blk, child_pos, root_new, parent_pos;
   logic [SUM_W-1:0]    cur_sum, f_sum, new_sum;
   logic [BLKX_W-1:0]   res_blk_wide;

   mfba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_heap (
      .clock    (clock),
      .wr_en    (heap_we),
      .wr_addr  (heap_wa),
      .wr_data  (heap_wd),
      .rd_en    (heap_re),
      .rd_addr0 (heap_ra0),
      .rd_addr1 (heap_ra1),
      .rd_data0 (heap_rd0),
      .rd_data1 (heap_rd1)
   );

   mfba_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BLOCKS)) u_fill (
      .clock    (clock),
      .wr_en    (fill_we),
      .wr_addr  (fill_wa),
      .wr_data  (fill_wd),
      .rd_en    (fill_re),
      .rd_addr0 (fill_ra0),
      .rd_addr1 (fill_ra1),
      .rd_data0 (fill_rd0),
      .rd_data1 (fill_rd1)
   );

   assign left_pos   = CH_W'({pos_ff, 1'b1});
   assign right_pos  = CH_W'({pos_ff, 1'b0}) + CH_W'(2);
   assign has_left   = left_pos < CH_W'(count_ff);
   assign has_right  = right_pos < CH_W'(count_ff);
   assign pick_right = has_right && (fill_rd1 < fill_rd0);
   assign child_key  = pick_right ? fill_rd1 : fill_rd0;
   assign child_blk  = pick_right ? heap_rd1 : heap_rd0;
   assign child_pos  = pick_right ? right_pos[IDX_W-1:0] : left_pos[IDX_W-1:0];
   assign descend    = child_key <= mov_key_ff;
   assign f_new      = descend ? child_key : mov_key_ff;
   assign root_new   = descend ? child_blk : mov_blk_ff;
   assign f_sum      = SUM_W'(f_ff) + SUM_W'(req_bytes_ff);
   assign new_sum    = SUM_W'(f_new) + SUM_W'(req_bytes_ff);
   assign cur_sum    = SUM_W'(cur_fill_ff) + SUM_W'(req_bytes_ff);
   assign fits_new   = new_sum <= BLOCK_LIM;
   assign full       = count_ff >= MAX_CNT;
   assign parent_pos = (pos_ff - IDX_W'(1)) >> 1;
   assign res_blk_wide = BLKX_W'(res_blk_ff);

   always_comb begin
      state_in      = state_ff;
      req_bytes_in  = req_bytes_ff;
      cur_blk_in    = cur_blk_ff;
      cur_fill_in   = cur_fill_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      mov_blk_in    = mov_blk_ff;
      mov_key_in    = mov_key_ff;
      root_in       = root_ff;
      f_in          = f_ff;
      fits_in       = fits_ff;
      res_status_in = res_status_ff;
      res_blk_in    = res_blk_ff;
      res_off_in    = res_off_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      heap_we  = 1'b0;
      heap_wa  = pos_ff;
      heap_wd  = mov_blk_ff;
      heap_re  = 1'b0;
      heap_ra0 = left_pos[IDX_W-1:0];
      heap_ra1 = left_pos[IDX_W-1:0];
      fill_we  = 1'b0;
      fill_wa  = cur_blk_ff;
      fill_wd  = cur_fill_ff;
      fill_re  = 1'b0;
      fill_ra0 = heap_rd0;
      fill_ra1 = heap_rd1;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               req_bytes_in = req_tdata;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cur_sum <= BLOCK_LIM) begin
               cur_fill_in   = cur_sum[FILL_W-1:0];
               res_status_in = 1'b0;
               res_blk_in    = cur_blk_ff;
               res_off_in    = cur_fill_ff;
               state_in      = ST_DONE;
            end else begin
               pos_in     = '0;
               mov_blk_in = cur_blk_ff;
               mov_key_in = cur_fill_ff;
               state_in   = ST_DN_HEAP;
            end
         end
         ST_DN_HEAP: begin
            if (has_left) begin
               heap_re  = 1'b1;
               heap_ra0 = left_pos[IDX_W-1:0];
               if (has_right) begin
                  heap_ra1 = right_pos[IDX_W-1:0];
               end
               state_in = ST_DN_FILL;
            end else begin
               heap_we  = 1'b1;
               state_in = ST_DN_DONE;
               if (pos_ff == '0) begin
                  root_in = cur_blk_ff;
                  f_in    = cur_fill_ff;
                  fits_in = 1'b0;
                  fill_we = 1'b1;
               end
            end
         end
         ST_DN_FILL: begin
            fill_re  = 1'b1;
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (pos_ff == '0 && !fits_new && full) begin
               res_status_in = 1'b1;
               res_blk_in    = '0;
               res_off_in    = '0;
               state_in      = ST_DONE;
            end else begin
               if (pos_ff == '0) begin
                  root_in = root_new;
                  f_in    = f_new;
                  fits_in = fits_new;
                  fill_we = 1'b1;
               end
               heap_we = 1'b1;
               if (descend) begin
                  heap_wd  = child_blk;
                  pos_in   = child_pos;
                  state_in = ST_DN_HEAP;
               end else begin
                  state_in = ST_DN_DONE;
               end
            end
         end
         ST_DN_DONE: begin
            cur_blk_in = root_ff;
            if (fits_ff) begin
               cur_fill_in   = f_sum[FILL_W-1:0];
               res_status_in = 1'b0;
               res_blk_in    = root_ff;
               res_off_in    = f_ff;
               state_in      = ST_DONE;
            end else begin
               fill_we     = 1'b1;
               fill_wa     = count_ff[IDX_W-1:0];
               fill_wd     = FILL_W'(req_bytes_ff) + HDR;
               cur_fill_in = f_ff;
               mov_key_in  = FILL_W'(req_bytes_ff) + HDR;
               mov_blk_in  = count_ff[IDX_W-1:0];
               pos_in      = count_ff[IDX_W-1:0];
               state_in    = ST_UP_HEAP;
            end
         end
         ST_UP_HEAP: begin
            if (pos_ff == '0) begin
               cur_blk_in    = mov_blk_ff;
               cur_fill_in   = mov_key_ff;
               count_in      = count_ff + CNT_W'(1);
               res_status_in = 1'b0;
               res_blk_in    = mov_blk_ff;
               res_off_in    = HDR;
               state_in      = ST_DONE;
            end else if (parent_pos == '0) begin
               heap_we = 1'b1;
               if (mov_key_ff > f_ff) begin
                  count_in      = count_ff + CNT_W'(1);
                  res_status_in = 1'b0;
                  res_blk_in    = mov_blk_ff;
                  res_off_in    = HDR;
                  state_in      = ST_DONE;
               end else begin
                  heap_wd = root_ff;
                  pos_in  = '0;
               end
            end else begin
               heap_re  = 1'b1;
               heap_ra0 = parent_pos;
               state_in = ST_UP_FILL;
            end
         end
         ST_UP_FILL: begin
            fill_re  = 1'b1;
            state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            heap_we = 1'b1;
            if (mov_key_ff > fill_rd0) begin
               count_in      = count_ff + CNT_W'(1);
               res_status_in = 1'b0;
               res_blk_in    = mov_blk_ff;
               res_off_in    = HDR;
               state_in      = ST_DONE;
            end else begin
               heap_wd  = heap_rd0;
               pos_in   = parent_pos;
               state_in = ST_UP_HEAP;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_blk_wide[BIDX_W-1:0];
               rsp_offset_in = res_off_ff[OFF_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_blk_ff    <= '0;
         cur_fill_ff   <= PREFIX;
         count_ff      <= CNT_W'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_blk_ff    <= cur_blk_in;
         cur_fill_ff   <= cur_fill_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_bytes_ff  <= req_bytes_in;
      pos_ff        <= pos_in;
      mov_blk_ff    <= mov_blk_in;
      mov_key_ff    <= mov_key_in;
      root_ff       <= root_in;
      f_ff          <= f_in;
      fits_ff       <= fits_in;
      res_status_ff <= res_status_in;
      res_blk_ff    <= res_blk_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_offset_ff, rsp_index_ff});

endmodule

FILE: hdl/mfba_check.sv
// Port-level assertions for the allocator, bound to its top level.
`timescale 1ns / 1ps

module mfba_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [mfba_pkg::REQ_W-1:0]      req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mfba_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import mfba_pkg::*;

   logic [REQ_W-1:0] req_seen;

   assign req_seen = req_tdata;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result transaction changed.");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_seen == req_tdata) |=> !req_tready)
      else $error("Block ready again in the cycle after a request transaction.");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[BIDX_W+OFF_W-1:0] == '0)
      else $error("Refused request carries a nonzero block index or offset.");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("Result appeared while no request was in work.");

endmodule

bind min_fill_block_arena_allocator mfba_check u_mfba_check (.*);
